>>> src/ubxnav_pkg.sv
package ubxnav_pkg;

    localparam logic [7:0] SYNC_1 = 8'hB5;
    localparam logic [7:0] SYNC_2 = 8'h62;

    localparam logic [7:0] CLS_NAV    = 8'h01;
    localparam logic [7:0] CLS_ACK    = 8'h05;
    localparam logic [7:0] ID_POSLLH  = 8'h02;
    localparam logic [7:0] ID_STATUS  = 8'h03;
    localparam logic [7:0] ID_SOL     = 8'h06;
    localparam logic [7:0] ID_PVT     = 8'h07;
    localparam logic [7:0] ID_VELNED  = 8'h12;
    localparam logic [7:0] ID_TIMEUTC = 8'h21;
    localparam logic [7:0] ID_ACK_ACK = 8'h01;
    localparam logic [7:0] ID_ACK_NAK = 8'h00;

    localparam logic [2:0] ST_BAD_SUM  = 3'd0;
    localparam logic [2:0] ST_NAV_CNT  = 3'd1;
    localparam logic [2:0] ST_NAV_UNC  = 3'd2;
    localparam logic [2:0] ST_ACK      = 3'd3;
    localparam logic [2:0] ST_NAK      = 3'd4;
    localparam logic [2:0] ST_IGNORED  = 3'd5;

    localparam logic [7:0] PAY_START = 8'd6;

    // payload bytes kept from one frame, grouped by their 4-byte word offset
    typedef struct packed {
        logic [31:0] w4;
        logic [31:0] w8;
        logic [31:0] w16;
        logic [31:0] w20;
        logic [31:0] w24;
        logic [31:0] w28;
        logic [31:0] w36;
        logic [7:0]  b44;
        logic [7:0]  b45;
        logic [7:0]  b47;
    } t_raw;

    typedef struct packed {
        logic       ok;
        logic [7:0] cls;
        logic [7:0] id;
        t_raw       raw;
    } t_frame;

    function automatic logic [16:0] pack_time(input logic [7:0] h, input logic [7:0] m,
                                              input logic [7:0] s);
        logic [4:0] hh;
        logic [5:0] mm;
        logic [5:0] ss;
        hh = (h > 8'd31) ? 5'd31 : h[4:0];
        mm = (m > 8'd63) ? 6'd63 : m[5:0];
        ss = (s > 8'd63) ? 6'd63 : s[5:0];
        return {hh, mm, ss};
    endfunction

endpackage

>>> src/ubxnav_front.sv
module ubxnav_front #(
    parameter int MAX_FRAME_BYTES = 128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [7:0]            i_byte,
    output logic                  o_push,
    output ubxnav_pkg::t_frame    o_frame
);

    localparam logic [8:0] MAX_POS = 9'(MAX_FRAME_BYTES);

    logic               r_in_sync, n_in_sync;
    logic [7:0]         r_pos, n_pos;
    logic [7:0]         r_sum_a, n_sum_a;
    logic [7:0]         r_sum_b, n_sum_b;
    logic [7:0]         r_cls, n_cls;
    logic [7:0]         r_id, n_id;
    logic [15:0]        r_len, n_len;
    logic [7:0]         r_ck_a, n_ck_a;
    ubxnav_pkg::t_raw   r_raw, n_raw;

    logic [16:0] pay_end;
    logic [7:0]  off;
    logic [4:0]  bsel;
    logic        last;
    logic        in_pay;
    logic [8:0]  pos_inc;
    logic [7:0]  sa_new;

    assign pay_end = 17'(r_len) + 17'(ubxnav_pkg::PAY_START);
    assign off     = r_pos - ubxnav_pkg::PAY_START;
    assign bsel    = {off[1:0], 3'b000};
    assign last    = (r_pos >= 8'd7) && (17'(r_pos) == pay_end + 17'd1);
    assign in_pay  = (r_pos >= ubxnav_pkg::PAY_START) && (17'(r_pos) < pay_end);
    assign pos_inc = 9'(r_pos) + 9'd1;
    assign sa_new  = r_sum_a + i_byte;

    always_comb begin
        n_in_sync = r_in_sync;
        n_pos     = r_pos;
        n_sum_a   = r_sum_a;
        n_sum_b   = r_sum_b;
        n_cls     = r_cls;
        n_id      = r_id;
        n_len     = r_len;
        n_ck_a    = r_ck_a;
        n_raw     = r_raw;
        o_push    = 1'b0;
        o_frame.ok  = (r_ck_a == r_sum_a) && (i_byte == r_sum_b);
        o_frame.cls = r_cls;
        o_frame.id  = r_id;
        o_frame.raw = r_raw;
        if (i_valid) begin
            if (!r_in_sync) begin
                if (r_pos == 8'd0 && i_byte == ubxnav_pkg::SYNC_1) begin
                    n_pos = 8'd1;
                end else if (r_pos == 8'd1 && i_byte == ubxnav_pkg::SYNC_2) begin
                    n_in_sync = 1'b1;
                    n_pos     = 8'd2;
                    n_sum_a   = 8'd0;
                    n_sum_b   = 8'd0;
                    n_raw     = '0;
                end else begin
                    n_pos = 8'd0;
                end
            end else if (last) begin
                o_push    = 1'b1;
                n_in_sync = 1'b0;
                n_pos     = 8'd0;
            end else begin
                case (r_pos)
                    8'd2: n_cls = i_byte;
                    8'd3: n_id = i_byte;
                    8'd4: n_len[7:0] = i_byte;
                    8'd5: n_len[15:8] = i_byte;
                    default: ;
                endcase
                if (r_pos >= ubxnav_pkg::PAY_START && 17'(r_pos) == pay_end) begin
                    n_ck_a = i_byte;
                end
                if (in_pay) begin
                    case (off[7:2])
                        6'd1:  n_raw.w4[bsel +: 8]  = i_byte;
                        6'd2:  n_raw.w8[bsel +: 8]  = i_byte;
                        6'd4:  n_raw.w16[bsel +: 8] = i_byte;
                        6'd5:  n_raw.w20[bsel +: 8] = i_byte;
                        6'd6:  n_raw.w24[bsel +: 8] = i_byte;
                        6'd7:  n_raw.w28[bsel +: 8] = i_byte;
                        6'd9:  n_raw.w36[bsel +: 8] = i_byte;
                        6'd11: begin
                            case (off[1:0])
                                2'd0: n_raw.b44 = i_byte;
                                2'd1: n_raw.b45 = i_byte;
                                2'd3: n_raw.b47 = i_byte;
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
                if (r_pos < ubxnav_pkg::PAY_START || in_pay) begin
                    n_sum_a = sa_new;
                    n_sum_b = r_sum_b + sa_new;
                end
                if (pos_inc >= MAX_POS) begin
                    n_in_sync = 1'b0;
                    n_pos     = 8'd0;
                end else begin
                    n_pos = pos_inc[7:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sync <= 1'b0;
            r_pos     <= 8'd0;
            r_sum_a   <= 8'd0;
            r_sum_b   <= 8'd0;
        end else begin
            r_in_sync <= n_in_sync;
            r_pos     <= n_pos;
            r_sum_a   <= n_sum_a;
            r_sum_b   <= n_sum_b;
        end
        r_cls  <= n_cls;
        r_id   <= n_id;
        r_len  <= n_len;
        r_ck_a <= n_ck_a;
        r_raw  <= n_raw;
    end

endmodule

>>> src/ubxnav_queue.sv
module ubxnav_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ubxnav_pkg::t_frame i_frame,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output ubxnav_pkg::t_frame o_frame
);

    ubxnav_pkg::t_frame r_mem [2];
    logic               r_wr, r_rd;
    logic [1:0]         r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_frame = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wr] <= i_frame;
        end
    end

endmodule

>>> src/ubxnav_back.sv
module ubxnav_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  ubxnav_pkg::t_frame i_frame,
    output logic               o_q_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [2:0]         o_frame_status,
    output logic signed [31:0] o_latitude,
    output logic signed [31:0] o_longitude,
    output logic signed [31:0] o_altitude_msl,
    output logic [31:0]        o_ground_speed,
    output logic [7:0]         o_fix_kind,
    output logic [2:0]         o_fix_flags,
    output logic [7:0]         o_satellites,
    output logic [15:0]        o_position_dop,
    output logic [16:0]        o_utc_time,
    output logic [15:0]        o_good_count,
    output logic [15:0]        o_bad_count
);

    logic        r_valid;
    logic [2:0]  r_status, n_status;
    logic [31:0] r_lat, n_lat, r_lon, n_lon, r_alt, n_alt, r_speed, n_speed;
    logic [7:0]  r_fix, n_fix, r_sats, n_sats;
    logic [2:0]  r_flags, n_flags;
    logic [15:0] r_dop, n_dop, r_good, n_good, r_bad, n_bad;
    logic [16:0] r_time, n_time;
    logic        take;
    ubxnav_pkg::t_raw rw;

    assign take    = !i_q_empty && (!r_valid || i_pop);
    assign o_q_pop = take;
    assign rw      = i_frame.raw;

    always_comb begin
        n_lat = r_lat; n_lon = r_lon; n_alt = r_alt; n_speed = r_speed;
        n_fix = r_fix; n_sats = r_sats; n_flags = r_flags; n_dop = r_dop;
        n_time = r_time; n_good = r_good; n_bad = r_bad;
        n_status = ubxnav_pkg::ST_IGNORED;
        if (!i_frame.ok) begin
            n_bad    = r_bad + 16'd1;
            n_status = ubxnav_pkg::ST_BAD_SUM;
        end else if (i_frame.cls == ubxnav_pkg::CLS_NAV) begin
            unique case (i_frame.id)
                ubxnav_pkg::ID_PVT: begin
                    n_fix    = rw.w20[7:0];
                    n_sats   = rw.w20[31:24];
                    n_lon    = rw.w24;
                    n_lat    = rw.w28;
                    n_alt    = rw.w36;
                    n_time   = ubxnav_pkg::pack_time(rw.w8[7:0], rw.w8[15:8], rw.w8[23:16]);
                    n_good   = r_good + 16'd1;
                    n_status = ubxnav_pkg::ST_NAV_CNT;
                end
                ubxnav_pkg::ID_POSLLH: begin
                    n_lon    = rw.w4;
                    n_lat    = rw.w8;
                    n_alt    = rw.w16;
                    n_good   = r_good + 16'd1;
                    n_status = ubxnav_pkg::ST_NAV_CNT;
                end
                ubxnav_pkg::ID_STATUS: begin
                    n_flags  = {rw.w4[25:24], rw.w4[8]};
                    n_good   = r_good + 16'd1;
                    n_status = ubxnav_pkg::ST_NAV_CNT;
                end
                ubxnav_pkg::ID_SOL: begin
                    n_fix    = rw.w8[23:16];
                    n_dop    = {rw.b45, rw.b44};
                    n_sats   = rw.b47;
                    n_status = ubxnav_pkg::ST_NAV_UNC;
                end
                ubxnav_pkg::ID_TIMEUTC: begin
                    n_time   = ubxnav_pkg::pack_time(rw.w16[7:0], rw.w16[15:8],
                                                     rw.w16[23:16]);
                    n_status = ubxnav_pkg::ST_NAV_UNC;
                end
                ubxnav_pkg::ID_VELNED: begin
                    n_speed  = rw.w20;
                    n_status = ubxnav_pkg::ST_NAV_UNC;
                end
                default: n_status = ubxnav_pkg::ST_IGNORED;
            endcase
        end else if (i_frame.cls == ubxnav_pkg::CLS_ACK) begin
            unique case (i_frame.id)
                ubxnav_pkg::ID_ACK_ACK: n_status = ubxnav_pkg::ST_ACK;
                ubxnav_pkg::ID_ACK_NAK: n_status = ubxnav_pkg::ST_NAK;
                default:                n_status = ubxnav_pkg::ST_IGNORED;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_lat <= '0; r_lon <= '0; r_alt <= '0; r_speed <= '0;
            r_fix <= '0; r_sats <= '0; r_flags <= '0; r_dop <= '0;
            r_time <= '0; r_good <= '0; r_bad <= '0;
        end else begin
            if (take) begin
                r_valid <= 1'b1;
                r_lat <= n_lat; r_lon <= n_lon; r_alt <= n_alt; r_speed <= n_speed;
                r_fix <= n_fix; r_sats <= n_sats; r_flags <= n_flags; r_dop <= n_dop;
                r_time <= n_time; r_good <= n_good; r_bad <= n_bad;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
        if (take) begin
            r_status <= n_status;
        end
    end

    assign o_empty        = !r_valid;
    assign o_frame_status = r_status;
    assign o_latitude     = r_lat;
    assign o_longitude    = r_lon;
    assign o_altitude_msl = r_alt;
    assign o_ground_speed = r_speed;
    assign o_fix_kind     = r_fix;
    assign o_fix_flags    = r_flags;
    assign o_satellites   = r_sats;
    assign o_position_dop = r_dop;
    assign o_utc_time     = r_time;
    assign o_good_count   = r_good;
    assign o_bad_count    = r_bad;

`ifndef ASSERT_OFF
    a_bad_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !i_frame.ok |=> r_bad == $past(r_bad) + 16'd1 && r_good == $past(r_good))
        else $error("bad frame not counted");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_status <= ubxnav_pkg::ST_IGNORED)
        else $error("status out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_pop |=> $stable(r_good) && $stable(r_bad) && $stable(r_status))
        else $error("waiting result changed");
    a_bad_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !i_frame.ok |=> r_status == ubxnav_pkg::ST_BAD_SUM)
        else $error("bad frame status wrong");
`endif

endmodule

>>> src/ubx_frame_receiver_nav_decoder_top.sv
// Frame receiver and navigation decoder for a UBX-style serial stream.
// Input channel: write one received byte on i_rx_byte with i_push; it is
// taken at a clock edge where i_push is high and o_full is low.
// Result channel: one item per completed frame (good or bad checksum).
// While o_empty is low, the status and the navigation record as it stands
// after that frame sit on the o_ ports; i_pop takes the item.
// Throughput: one byte per cycle while o_full is low. The framer handles
// each byte in the cycle it is taken; a two-entry frame queue feeds the
// decoder, which updates the record and loads the result register when
// that register is empty or being popped.
// Frames of up to MAX_FRAME_BYTES bytes are accepted; longer ones are
// dropped with no result.
// Reset clears sync, checksum, the record and both counters.
// When results are not popped, the queue fills; o_full then rises only
// once two finished frames are waiting behind the result register.
module ubx_frame_receiver_nav_decoder_top #(
    parameter int MAX_FRAME_BYTES = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [7:0]         i_rx_byte,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [2:0]         o_frame_status,
    output logic signed [31:0] o_latitude,
    output logic signed [31:0] o_longitude,
    output logic signed [31:0] o_altitude_msl,
    output logic [31:0]        o_ground_speed,
    output logic [7:0]         o_fix_kind,
    output logic [2:0]         o_fix_flags,
    output logic [7:0]         o_satellites,
    output logic [15:0]        o_position_dop,
    output logic [16:0]        o_utc_time,
    output logic [15:0]        o_good_count,
    output logic [15:0]        o_bad_count
);

    logic               f_push, q_empty, q_pop, q_full;
    ubxnav_pkg::t_frame f_frame, q_frame;

    assign o_full = q_full;

    ubxnav_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_push && !q_full), .i_byte(i_rx_byte),
        .o_push(f_push), .o_frame(f_frame)
    );

    ubxnav_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(f_push), .i_frame(f_frame), .o_full(q_full),
        .i_pop(q_pop), .o_empty(q_empty), .o_frame(q_frame)
    );

    ubxnav_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_empty(q_empty), .i_frame(q_frame), .o_q_pop(q_pop),
        .o_empty(o_empty), .i_pop(i_pop),
        .o_frame_status(o_frame_status), .o_latitude(o_latitude),
        .o_longitude(o_longitude), .o_altitude_msl(o_altitude_msl),
        .o_ground_speed(o_ground_speed), .o_fix_kind(o_fix_kind),
        .o_fix_flags(o_fix_flags), .o_satellites(o_satellites),
        .o_position_dop(o_position_dop), .o_utc_time(o_utc_time),
        .o_good_count(o_good_count), .o_bad_count(o_bad_count)
    );

endmodule
